/* hdl/stb_pkg.sv */
// Package with the shared codes, widths and control structures of the timer bank.
package stb_pkg;

    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_TIME_WIDTH = 32;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int DELTA_W  = 16;
    localparam int PERIOD_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    typedef struct packed {
        logic start;
        logic scan;
        logic flush;
        logic add;
        logic remove;
    } stb_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic flush_ok;
    } stb_status_t;

endpackage

/* hdl/stb_ctrl.sv */
// Controller state machine that sequences commands, tick scans and the final flush.
module stb_ctrl
    import stb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] func,
    output logic              in_ready,
    output stb_cmd_t          cmd,
    input  stb_status_t       status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (func)
                        FUNC_TICK:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_SCAN;
                        end
                        FUNC_ADD:    cmd.add    = 1'b1;
                        FUNC_REMOVE: cmd.remove = 1'b1;
                        default:     ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (status.flush_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/stb_datapath.sv */
// Datapath with the slot memories, live bits, scan pipeline and result registers.
module stb_datapath
    import stb_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  stb_cmd_t            cmd,
    output stb_status_t         status,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [DELTA_W-1:0]  delta,
    input  logic [PERIOD_W-1:0] period,
    input  logic                keep_running,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SLOT_W-1:0]   fired_slot,
    output logic                last_fired
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int SUM_W = ((TIME_WIDTH > DELTA_W) ? TIME_WIDTH : DELTA_W) + 1;
    localparam int PER_W = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    logic [TIME_WIDTH:0]   cfg_mem [NUM_SLOTS];
    logic [TIME_WIDTH-1:0] acc_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  live_reg;

    logic [CNT_W-1:0]      rd_idx_reg;
    logic                  ev_valid_reg;
    logic [IDX_W-1:0]      ev_idx_reg;
    logic [TIME_WIDTH:0]   cfg_rd_reg;
    logic [TIME_WIDTH-1:0] acc_rd_reg;
    logic [DELTA_W-1:0]    delta_reg;

    logic                  pend_valid_reg;
    logic [SLOT_W-1:0]     pend_slot_reg;
    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_last_reg;

    logic                  slot_ok;
    logic [IDX_W-1:0]      slot_idx;
    logic [PER_W-1:0]      per_ext;
    logic [TIME_WIDTH-1:0] per_sat;
    logic                  rd_more;
    logic                  out_free;
    logic                  ev_live;
    logic                  ev_fire;
    logic                  stall;
    logic                  advance;
    logic                  rd_en;
    logic [SUM_W-1:0]      sum_run;
    logic [SUM_W-1:0]      sum_fire;
    logic [TIME_WIDTH-1:0] acc_run;
    logic [TIME_WIDTH-1:0] acc_fire;
    logic [TIME_WIDTH-1:0] acc_new;
    logic                  push;
    logic                  push_last;

    assign slot_ok  = (32'(slot) < NUM_SLOTS);
    assign slot_idx = IDX_W'(slot);
    assign per_ext  = PER_W'(period);
    assign per_sat  = (per_ext > PER_W'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(per_ext);

    assign rd_more  = (rd_idx_reg < CNT_W'(NUM_SLOTS));
    assign out_free = !out_valid_reg || out_ready;
    assign ev_live  = ev_valid_reg && live_reg[ev_idx_reg];
    assign ev_fire  = ev_live && (acc_rd_reg >= cfg_rd_reg[TIME_WIDTH-1:0]);
    assign stall    = ev_fire && pend_valid_reg && !out_free;
    assign advance  = cmd.scan && !stall;
    assign rd_en    = advance && rd_more;

    assign sum_run  = SUM_W'(acc_rd_reg) + SUM_W'(delta_reg);
    assign sum_fire = SUM_W'(delta_reg);
    assign acc_run  = (sum_run > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(sum_run);
    assign acc_fire = (sum_fire > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(sum_fire);
    assign acc_new  = ev_fire ? acc_fire : acc_run;

    assign push      = (advance && ev_fire && pend_valid_reg)
                     || (cmd.flush && pend_valid_reg && out_free);
    assign push_last = cmd.flush;

    assign status.scan_done = !rd_more && !ev_valid_reg;
    assign status.flush_ok  = !pend_valid_reg || out_free;

    assign out_valid  = out_valid_reg;
    assign fired_slot = out_slot_reg;
    assign last_fired = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.add && slot_ok)
        begin
            cfg_mem[slot_idx] <= {keep_running, per_sat};
            acc_mem[slot_idx] <= '0;
        end
        else if (advance && ev_live)
        begin
            acc_mem[ev_idx_reg] <= acc_new;
        end
        if (rd_en)
        begin
            cfg_rd_reg <= cfg_mem[rd_idx_reg[IDX_W-1:0]];
            acc_rd_reg <= acc_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            rd_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.add && slot_ok)
            begin
                live_reg[slot_idx] <= 1'b1;
            end
            else if (cmd.remove && slot_ok)
            begin
                live_reg[slot_idx] <= 1'b0;
            end
            else if (advance && ev_fire && !cfg_rd_reg[TIME_WIDTH])
            begin
                live_reg[ev_idx_reg] <= 1'b0;
            end

            if (cmd.start)
            begin
                rd_idx_reg   <= '0;
                ev_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                ev_valid_reg <= rd_more;
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end

            if (advance && ev_fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush && out_free)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            delta_reg <= delta;
        end
        if (rd_en)
        begin
            ev_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (advance && ev_fire)
        begin
            pend_slot_reg <= SLOT_W'(ev_idx_reg);
        end
        if (push)
        begin
            out_slot_reg <= pend_slot_reg;
            out_last_reg <= push_last;
        end
    end

endmodule

/* hdl/software_timer_bank_unit.sv */
// Top level of the software timer bank: controller, datapath and stream ports.
//
//  Channel   Direction  Signals                        Contents
//  s_axis    in         tvalid tready tdata tuser      one command item
//  m_axis    out        tvalid tready tdata tlast      one fired slot item
//
// Add, remove and unknown commands are handled in the idle state. A tick is
// accepted there too; the scan state then reads one slot per cycle while not
// stalled, each read passes the registered read stage, the scan end is seen
// and the flush state releases any held final item. A firing that meets a
// pending item waits on the single output register, so a stalled m_axis
// lengthens the tick scan. Reset clears all slots to empty at once.
module software_timer_bank_unit
    import stb_pkg::*;
#(
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // slot[3:0], delta[19:4], period[51:20],
                                        // keep_running[52], zero fill
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // fired_slot[3:0], zero fill
    output logic        m_axis_tlast    // last_fired
);

    stb_cmd_t          cmd;
    stb_status_t       status;
    logic [SLOT_W-1:0] fired_slot;

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .func     (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    stb_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .slot         (s_axis_tdata[3:0]),
        .delta        (s_axis_tdata[19:4]),
        .period       (s_axis_tdata[51:20]),
        .keep_running (s_axis_tdata[52]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .fired_slot   (fired_slot),
        .last_fired   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, fired_slot};

endmodule
